### src/bsfd_pkg.sv
package bsfd_pkg;

   // Framing bytes
   localparam logic [7:0] BOUNDARY_BYTE  = 8'h7E;
   localparam logic [7:0] ESCAPE_BYTE    = 8'h7D;
   localparam logic [7:0] ESCAPED_ESCAPE = 8'h00;

   // Register indexes and reset values
   localparam logic       CSR_TYPE_CODE_FIRST    = 1'b0;
   localparam logic       CSR_TYPE_CODE_SECOND   = 1'b1;
   localparam logic [7:0] TYPE_CODE_FIRST_RESET  = 8'd0;
   localparam logic [7:0] TYPE_CODE_SECOND_RESET = 8'd1;

   // Microprogram steps
   typedef enum logic [1:0] {
      STEP_ACCEPT,
      STEP_READ,
      STEP_EMIT
   } step_type;

   // Jump conditions
   typedef enum logic [1:0] {
      COND_NEVER,
      COND_DONE,
      COND_LAST
   } cond_type;

   // One control word of the microprogram
   typedef struct packed {
      logic     accept;     // take a byte from the request channel
      logic     mem_read;   // read the payload store at the drain index
      logic     emit;       // load the result register
      logic     wait_out;   // hold the step while the result register is busy
      cond_type cond;       // jump condition
      step_type jump_step;  // step when the condition holds
      step_type next_step;  // step otherwise
   } ctl_word_type;

   // Datapath status fed back to the sequencer
   typedef struct packed {
      logic frame_done;     // accepted beat completes a frame
      logic out_free;       // result register can take a beat
      logic last_beat;      // drain index is at the final result
   } status_type;

   // Control store
   function automatic ctl_word_type ctl_rom(input step_type step);
      ctl_word_type word;
      word = '0;
      unique case (step)
         STEP_ACCEPT: begin
            word.accept    = 1'b1;
            word.cond      = COND_DONE;
            word.jump_step = STEP_READ;
            word.next_step = STEP_ACCEPT;
         end
         STEP_READ: begin
            word.mem_read  = 1'b1;
            word.cond      = COND_NEVER;
            word.jump_step = STEP_EMIT;
            word.next_step = STEP_EMIT;
         end
         STEP_EMIT: begin
            word.emit      = 1'b1;
            word.wait_out  = 1'b1;
            word.cond      = COND_LAST;
            word.jump_step = STEP_ACCEPT;
            word.next_step = STEP_READ;
         end
         default: begin
            word.cond      = COND_NEVER;
            word.jump_step = STEP_ACCEPT;
            word.next_step = STEP_ACCEPT;
         end
      endcase
      return word;
   endfunction

endpackage

### src/bsfd_seq.sv
module bsfd_seq (
   input  logic                   clock,
   input  logic                   reset,
   input  bsfd_pkg::status_type   status,
   output bsfd_pkg::ctl_word_type ctl
);

   bsfd_pkg::step_type step_ff;
   bsfd_pkg::step_type step_in;
   logic               cond_true;

   // Look up the control word of the current step
   always_comb begin
      ctl = bsfd_pkg::ctl_rom(step_ff);
   end

   // Pick the next step: hold, jump or fall through
   always_comb begin
      case (ctl.cond)
         bsfd_pkg::COND_DONE: cond_true = status.frame_done;
         bsfd_pkg::COND_LAST: cond_true = status.last_beat;
         default:             cond_true = 1'b0;
      endcase
      if (ctl.wait_out && !status.out_free) begin
         step_in = step_ff;
      end else if (cond_true) begin
         step_in = ctl.jump_step;
      end else begin
         step_in = ctl.next_step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= bsfd_pkg::STEP_ACCEPT;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

### src/byte_stuffed_frame_deframer.sv
// Receive-side deframer for a byte-stuffed link. Bytes are taken one per
// cycle while a frame is hunted for and collected: the block waits for 0x7E,
// undoes the 0x7D escapes, keeps the type byte if it matches either
// configured code, takes the next byte as the payload length and stores the
// payload. A bare 0x7E or a bad escape drops the partial frame. When the
// stored count reaches the length, the request side is stalled and the
// frame drains as max(length, 1) result beats; each beat first reads the
// payload store and then loads the result register, waiting while
// rsp_stall holds the result register. After the last beat the block is
// back in the hunt state, as after reset. A declared length above
// PAYLOAD_DEPTH never completes.
module byte_stuffed_frame_deframer #(
   parameter int PAYLOAD_DEPTH = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic       csr_index,
   input  logic [7:0] csr_wr_data,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_frame_type,
   output logic [6:0] rsp_frame_length,
   output logic [7:0] rsp_payload_byte,
   output logic       rsp_empty_frame,
   output logic       rsp_last_of_frame
);

   localparam int AW    = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
   localparam int CNT_W = $clog2(PAYLOAD_DEPTH + 1);

   bsfd_pkg::ctl_word_type ctl;
   bsfd_pkg::status_type   status;

   logic [7:0] type_first_ff;
   logic [7:0] type_second_ff;

   logic             boundary_seen_ff,   boundary_seen_in;
   logic             escape_pending_ff,  escape_pending_in;
   logic             type_known_ff,      type_known_in;
   logic [7:0]       held_type_ff,       held_type_in;
   logic             length_known_ff,    length_known_in;
   logic [7:0]       declared_length_ff, declared_length_in;
   logic [CNT_W-1:0] stored_count_ff,    stored_count_in;
   logic [CNT_W-1:0] drain_idx_ff,       drain_idx_in;

   logic [7:0] store_mem [PAYLOAD_DEPTH];
   logic [7:0] rd_data_ff;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_type_ff;
   logic [6:0] rsp_length_ff;
   logic [7:0] rsp_payload_ff;
   logic       rsp_empty_ff;
   logic       rsp_last_ff;

   logic       beat_in;
   logic       have_data;
   logic [7:0] data_byte;
   logic       store_we;
   logic       load_out;
   logic       empty_len;
   logic       out_free;
   logic       last_beat;

   bsfd_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctl    (ctl)
   );

   assign req_stall = !ctl.accept;
   assign beat_in   = req_valid && ctl.accept;
   assign empty_len = (declared_length_ff == 8'd0);

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         type_first_ff  <= bsfd_pkg::TYPE_CODE_FIRST_RESET;
         type_second_ff <= bsfd_pkg::TYPE_CODE_SECOND_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            bsfd_pkg::CSR_TYPE_CODE_FIRST:  type_first_ff  <= csr_wr_data;
            bsfd_pkg::CSR_TYPE_CODE_SECOND: type_second_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // Result register room and drain position
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign last_beat = empty_len || ((8'(drain_idx_ff) + 8'd1) == declared_length_ff);
   assign load_out  = ctl.emit && out_free;

   // Decode one incoming byte and advance the frame state
   always_comb begin
      boundary_seen_in   = boundary_seen_ff;
      escape_pending_in  = escape_pending_ff;
      type_known_in      = type_known_ff;
      held_type_in       = held_type_ff;
      length_known_in    = length_known_ff;
      declared_length_in = declared_length_ff;
      stored_count_in    = stored_count_ff;
      drain_idx_in       = drain_idx_ff;
      have_data          = 1'b0;
      data_byte          = req_rx_byte;
      store_we           = 1'b0;

      if (beat_in) begin
         if (!boundary_seen_ff) begin
            // hunt for the opening boundary
            if (req_rx_byte == bsfd_pkg::BOUNDARY_BYTE) begin
               boundary_seen_in = 1'b1;
            end
         end else if (!escape_pending_ff) begin
            if (req_rx_byte == bsfd_pkg::ESCAPE_BYTE) begin
               escape_pending_in = 1'b1;
            end else if (req_rx_byte == bsfd_pkg::BOUNDARY_BYTE) begin
               // drop the partial frame, stay synchronized
               escape_pending_in  = 1'b0;
               type_known_in      = 1'b0;
               held_type_in       = 8'd0;
               length_known_in    = 1'b0;
               declared_length_in = 8'd0;
               stored_count_in    = '0;
            end else begin
               have_data = 1'b1;
            end
         end else begin
            escape_pending_in = 1'b0;
            if (req_rx_byte == bsfd_pkg::BOUNDARY_BYTE) begin
               have_data = 1'b1;
            end else if (req_rx_byte == bsfd_pkg::ESCAPED_ESCAPE) begin
               have_data = 1'b1;
               data_byte = bsfd_pkg::ESCAPE_BYTE;
            end else begin
               // bad escape: drop the partial frame
               type_known_in      = 1'b0;
               held_type_in       = 8'd0;
               length_known_in    = 1'b0;
               declared_length_in = 8'd0;
               stored_count_in    = '0;
            end
         end

         if (have_data) begin
            if (!type_known_ff) begin
               if (data_byte == type_first_ff || data_byte == type_second_ff) begin
                  held_type_in  = data_byte;
                  type_known_in = 1'b1;
               end
            end else if (!length_known_ff) begin
               declared_length_in = data_byte;
               stored_count_in    = '0;
               length_known_in    = 1'b1;
            end else if (stored_count_ff < CNT_W'(PAYLOAD_DEPTH)) begin
               store_we        = 1'b1;
               stored_count_in = stored_count_ff + CNT_W'(1);
            end
         end
      end

      // Step the drain index, clear everything after the last beat
      if (load_out) begin
         if (last_beat) begin
            boundary_seen_in   = 1'b0;
            escape_pending_in  = 1'b0;
            type_known_in      = 1'b0;
            held_type_in       = 8'd0;
            length_known_in    = 1'b0;
            declared_length_in = 8'd0;
            stored_count_in    = '0;
            drain_idx_in       = '0;
         end else begin
            drain_idx_in = drain_idx_ff + CNT_W'(1);
         end
      end
   end

   // Status for the sequencer
   always_comb begin
      status.frame_done = beat_in && length_known_in
                          && (8'(stored_count_in) == declared_length_in);
      status.out_free   = out_free;
      status.last_beat  = last_beat;
   end

   // Frame state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         boundary_seen_ff   <= 1'b0;
         escape_pending_ff  <= 1'b0;
         type_known_ff      <= 1'b0;
         held_type_ff       <= 8'd0;
         length_known_ff    <= 1'b0;
         declared_length_ff <= 8'd0;
         stored_count_ff    <= '0;
         drain_idx_ff       <= '0;
      end else begin
         boundary_seen_ff   <= boundary_seen_in;
         escape_pending_ff  <= escape_pending_in;
         type_known_ff      <= type_known_in;
         held_type_ff       <= held_type_in;
         length_known_ff    <= length_known_in;
         declared_length_ff <= declared_length_in;
         stored_count_ff    <= stored_count_in;
         drain_idx_ff       <= drain_idx_in;
      end
   end

   // Payload store: write on collect, registered read on drain
   always_ff @(posedge clock) begin
      if (store_we) begin
         store_mem[stored_count_ff[AW-1:0]] <= data_byte;
      end
      if (ctl.mem_read) begin
         rd_data_ff <= store_mem[drain_idx_ff[AW-1:0]];
      end
   end

   // Result register
   always_comb begin
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_type_ff    <= held_type_ff;
         rsp_length_ff  <= declared_length_ff[6:0];
         rsp_payload_ff <= empty_len ? 8'd0 : rd_data_ff;
         rsp_empty_ff   <= empty_len;
         rsp_last_ff    <= last_beat;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_frame_type    = rsp_type_ff;
   assign rsp_frame_length  = rsp_length_ff;
   assign rsp_payload_byte  = rsp_payload_ff;
   assign rsp_empty_frame   = rsp_empty_ff;
   assign rsp_last_of_frame = rsp_last_ff;

   // Store writes stay inside the memory
   assert property (@(posedge clock) disable iff (reset)
      store_we |-> (stored_count_ff < CNT_W'(PAYLOAD_DEPTH)))
      else $error("payload store write past depth");

   // While draining, the frame is complete and held
   assert property (@(posedge clock) disable iff (reset)
      !ctl.accept |-> (length_known_ff && (8'(stored_count_ff) == declared_length_ff)))
      else $error("drain without a complete frame");

   // Drain index stays below the stored count
   assert property (@(posedge clock) disable iff (reset)
      (!ctl.accept && !empty_len) |-> (drain_idx_ff < stored_count_ff))
      else $error("drain index out of range");

   // Last beat returns the frame state to the hunt
   assert property (@(posedge clock) disable iff (reset)
      (load_out && last_beat) |=> (!boundary_seen_ff && !length_known_ff
                                   && ctl.accept))
      else $error("frame state not cleared after last beat");

endmodule

### tb/sv/tb_byte_stuffed_frame_deframer.sv
`timescale 1ns / 100ps

// One result beat of a drained frame
typedef struct packed {
   logic [7:0] ftype;
   logic [6:0] flen;
   logic [7:0] data;
   logic       is_empty;
   logic       is_last;
} frame_beat_type;

// Deframer predictor plus the queue of beats it expects
class frame_scoreboard;
   localparam int STORE_DEPTH = 64;

   bit [7:0]       code_first;
   bit [7:0]       code_second;
   bit             in_frame;
   bit             esc_pending;
   bit             type_known;
   bit [7:0]       held_type;
   bit             len_known;
   bit [7:0]       decl_len;
   bit [6:0]       stored_count;
   bit [7:0]       store [STORE_DEPTH];
   frame_beat_type expected_beats [$];
   int             errors;

   function new();
      code_first  = bsfd_pkg::TYPE_CODE_FIRST_RESET;
      code_second = bsfd_pkg::TYPE_CODE_SECOND_RESET;
      errors      = 0;
      clear_frame();
   endfunction

   function void clear_frame();
      in_frame     = 1'b0;
      esc_pending  = 1'b0;
      type_known   = 1'b0;
      held_type    = 8'h00;
      len_known    = 1'b0;
      decl_len     = 8'h00;
      stored_count = 7'd0;
   endfunction

   function void set_code(logic idx, logic [7:0] value);
      if (idx == bsfd_pkg::CSR_TYPE_CODE_FIRST) begin
         code_first = value;
      end else begin
         code_second = value;
      end
   endfunction

   function int beats_pending();
      return expected_beats.size();
   endfunction

   // Advance the deframer by one accepted byte; queue any drained beats
   function void note_byte(logic [7:0] raw);
      bit [7:0]       b;
      bit             have_data;
      int             n;
      int             k;
      frame_beat_type beat;
      b = raw;
      have_data = 1'b0;
      // hunt for the opening boundary
      if (!in_frame) begin
         if (b == bsfd_pkg::BOUNDARY_BYTE) in_frame = 1'b1;
         return;
      end
      // undo escapes; a bare boundary or bad escape restarts the frame
      if (!esc_pending) begin
         if (b == bsfd_pkg::ESCAPE_BYTE) begin
            esc_pending = 1'b1;
         end else if (b == bsfd_pkg::BOUNDARY_BYTE) begin
            clear_frame();
            in_frame = 1'b1;
            return;
         end else begin
            have_data = 1'b1;
         end
      end else begin
         esc_pending = 1'b0;
         if (b == bsfd_pkg::BOUNDARY_BYTE) begin
            have_data = 1'b1;
         end else if (b == bsfd_pkg::ESCAPED_ESCAPE) begin
            b = bsfd_pkg::ESCAPE_BYTE;
            have_data = 1'b1;
         end else begin
            clear_frame();
            in_frame = 1'b1;
            return;
         end
      end
      // type, then length, then payload; drop bytes past the store
      if (have_data) begin
         if (!type_known) begin
            if (b == code_first || b == code_second) begin
               held_type  = b;
               type_known = 1'b1;
            end
         end else if (!len_known) begin
            decl_len     = b;
            stored_count = 7'd0;
            len_known    = 1'b1;
         end else if (stored_count < STORE_DEPTH) begin
            store[stored_count[5:0]] = b;
            stored_count++;
         end
      end
      // drain a completed frame
      if (len_known && {1'b0, stored_count} == decl_len) begin
         n = (decl_len == 0) ? 1 : int'(decl_len);
         for (k = 0; k < n; k++) begin
            beat.ftype    = held_type;
            beat.flen     = decl_len[6:0];
            beat.data     = (decl_len == 0) ? 8'h00 : store[k[5:0]];
            beat.is_empty = (decl_len == 0);
            beat.is_last  = (k == n - 1);
            expected_beats.push_back(beat);
         end
         clear_frame();
      end
   endfunction

   function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         errors++;
      end
   endfunction

   // Check one accepted result beat against the oldest expectation
   function void check_beat(frame_beat_type got);
      frame_beat_type want;
      if (expected_beats.size() == 0) begin
         $display("%0t: unexpected beat, expected none, actual type %0h len %0d data %0h",
                  $time, got.ftype, got.flen, got.data);
         errors++;
         return;
      end
      want = expected_beats.pop_front();
      compare_field("frame_type", want.ftype, got.ftype);
      compare_field("frame_length", {1'b0, want.flen}, {1'b0, got.flen});
      compare_field("payload_byte", want.data, got.data);
      compare_field("empty_frame", {7'd0, want.is_empty}, {7'd0, got.is_empty});
      compare_field("last_of_frame", {7'd0, want.is_last}, {7'd0, got.is_last});
   endfunction
endclass

module tb_byte_stuffed_frame_deframer;

   logic       clock = 1'b0;
   logic       reset;
   logic       csr_wr_en;
   logic       csr_index;
   logic [7:0] csr_wr_data;
   logic       req_valid;
   logic       req_stall;
   logic [7:0] req_rx_byte;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_frame_type;
   logic [6:0] rsp_frame_length;
   logic [7:0] rsp_payload_byte;
   logic       rsp_empty_frame;
   logic       rsp_last_of_frame;

   int idle_pct   = 0;
   int stall_pct  = 0;
   int bytes_sent = 0;

   frame_scoreboard deframer_sb = new();

   // Hunt noise, empty frame, skipped type with escapes, bare boundary, bad escape, one-byte frame
   localparam logic [7:0] OPENING_BYTES [24] = '{
      8'hFF,
      bsfd_pkg::BOUNDARY_BYTE, bsfd_pkg::TYPE_CODE_FIRST_RESET, 8'h00,
      bsfd_pkg::BOUNDARY_BYTE, 8'h55, bsfd_pkg::TYPE_CODE_SECOND_RESET, 8'h03,
      bsfd_pkg::ESCAPE_BYTE, bsfd_pkg::BOUNDARY_BYTE, bsfd_pkg::ESCAPE_BYTE,
      bsfd_pkg::ESCAPED_ESCAPE, 8'hFF,
      bsfd_pkg::BOUNDARY_BYTE, bsfd_pkg::TYPE_CODE_FIRST_RESET, 8'h05, 8'h11,
      bsfd_pkg::BOUNDARY_BYTE, bsfd_pkg::TYPE_CODE_SECOND_RESET, bsfd_pkg::ESCAPE_BYTE,
      8'h33,
      bsfd_pkg::TYPE_CODE_FIRST_RESET, 8'h01, 8'h80
   };

   byte_stuffed_frame_deframer i_dut (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wr_data       (csr_wr_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_frame_type    (rsp_frame_type),
      .rsp_frame_length  (rsp_frame_length),
      .rsp_payload_byte  (rsp_payload_byte),
      .rsp_empty_frame   (rsp_empty_frame),
      .rsp_last_of_frame (rsp_last_of_frame)
   );

   always #2 clock = ~clock;

   // Stall the result side at random
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // Check every accepted result beat
   always @(posedge clock) begin
      frame_beat_type got_beat;
      if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         got_beat.ftype    = rsp_frame_type;
         got_beat.flen     = rsp_frame_length;
         got_beat.data     = rsp_payload_byte;
         got_beat.is_empty = rsp_empty_frame;
         got_beat.is_last  = rsp_last_of_frame;
         deframer_sb.check_beat(got_beat);
      end
   end

   // Bias toward framing bytes and the byte extremes
   function automatic logic [7:0] pick_byte();
      logic [7:0] special [4];
      special = '{bsfd_pkg::BOUNDARY_BYTE, bsfd_pkg::ESCAPE_BYTE, 8'h00, 8'hFF};
      if ($urandom_range(99) < 20) return special[2'($urandom_range(3))];
      return 8'($urandom_range(255));
   endfunction

   function automatic logic [7:0] pick_code();
      return $urandom_range(1) ? deframer_sb.code_first : deframer_sb.code_second;
   endfunction

   // Mostly short payloads, some empty, a few from 40 up to the store depth
   function automatic int pick_length();
      int r;
      r = $urandom_range(99);
      if (r < 4) return $urandom_range(40, 64);
      if (r < 15) return 0;
      return $urandom_range(1, 8);
   endfunction

   // Send one beat after a random idle gap
   task automatic send_byte(input logic [7:0] value);
      while ($urandom_range(99) < idle_pct) begin
         @(negedge clock);
         req_valid   <= 1'b0;
         req_rx_byte <= 8'($urandom_range(255));
      end
      @(negedge clock);
      req_valid   <= 1'b1;
      req_rx_byte <= value;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      deframer_sb.note_byte(value);
      bytes_sent++;
   endtask

   // Escape framing bytes inside a frame
   task automatic send_stuffed(input logic [7:0] value);
      if (value == bsfd_pkg::BOUNDARY_BYTE) begin
         send_byte(bsfd_pkg::ESCAPE_BYTE);
         send_byte(bsfd_pkg::BOUNDARY_BYTE);
      end else if (value == bsfd_pkg::ESCAPE_BYTE) begin
         send_byte(bsfd_pkg::ESCAPE_BYTE);
         send_byte(bsfd_pkg::ESCAPED_ESCAPE);
      end else begin
         send_byte(value);
      end
   endtask

   // Boundary, skipped types, type, length and n_pay payload bytes
   task automatic send_frame(input logic [7:0] type_byte, input logic [7:0] len,
                             input int n_pay, input int n_skip);
      logic [7:0] other;
      send_byte(bsfd_pkg::BOUNDARY_BYTE);
      repeat (n_skip) begin
         do begin
            other = 8'($urandom_range(255));
         end while (other == deframer_sb.code_first || other == deframer_sb.code_second);
         send_stuffed(other);
      end
      send_stuffed(type_byte);
      send_stuffed(len);
      repeat (n_pay) send_stuffed(pick_byte());
   endtask

   // Hold the sender until every expected beat has arrived
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (deframer_sb.beats_pending() != 0) @(posedge clock);
   endtask

   task automatic settle_block();
      wait_drained();
      repeat (8) @(posedge clock);
   endtask

   task automatic write_code(input logic idx, input logic [7:0] value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      deframer_sb.set_code(idx, value);
   endtask

   // Mostly well-formed frames, the rest broken frames and line noise
   task automatic run_random(input int quota);
      int start_count;
      int kind;
      int len;
      logic [7:0] bad;
      start_count = bytes_sent;
      while (bytes_sent - start_count < quota) begin
         kind = $urandom_range(99);
         if (kind < 60) begin
            len = pick_length();
            send_frame(pick_code(), 8'(len), len, 0);
         end else if (kind < 68) begin
            // skipped type bytes ahead of a good frame
            len = pick_length();
            send_frame(pick_code(), 8'(len), len, $urandom_range(1, 2));
         end else if (kind < 75) begin
            // truncate; the next boundary drops it
            len = $urandom_range(1, 8);
            send_frame(pick_code(), 8'(len), $urandom_range(len - 1), 0);
         end else if (kind < 83) begin
            // bad escape mid-frame
            len = $urandom_range(1, 8);
            send_frame(pick_code(), 8'(len), $urandom_range(len - 1), 0);
            bad = 8'($urandom_range(1, 254));
            if (bad >= bsfd_pkg::BOUNDARY_BYTE) bad++;
            send_byte(bsfd_pkg::ESCAPE_BYTE);
            send_byte(bad);
         end else if (kind < 88) begin
            // declared length past the store depth
            send_frame(pick_code(), 8'($urandom_range(65, 255)), $urandom_range(0, 8), 0);
         end else begin
            repeat ($urandom_range(1, 4)) send_byte(pick_byte());
         end
         if ($urandom_range(9) == 0) wait_drained();
      end
   endtask

   task automatic run_phase(input logic [7:0] first_code, input logic [7:0] second_code,
                            input int sender_idle, input int receiver_stall,
                            input bit with_long, input int quota);
      settle_block();
      write_code(bsfd_pkg::CSR_TYPE_CODE_FIRST, first_code);
      write_code(bsfd_pkg::CSR_TYPE_CODE_SECOND, second_code);
      idle_pct  = sender_idle;
      stall_pct = receiver_stall;
      if (with_long) begin
         // full store, then an overlong frame that spills past it
         send_frame(first_code, 8'd64, 64, 0);
         send_frame(second_code, 8'hFF, 65, 0);
      end
      run_random(quota);
   endtask

   initial begin
      reset       = 1'b1;
      csr_wr_en   = 1'b0;
      csr_index   = bsfd_pkg::CSR_TYPE_CODE_FIRST;
      csr_wr_data = 8'h00;
      req_valid   = 1'b0;
      req_rx_byte = 8'h00;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (OPENING_BYTES[i]) send_byte(OPENING_BYTES[i]);

      run_phase(8'h00, 8'hFF, 0, 0, 1'b1, 0);
      run_phase(bsfd_pkg::BOUNDARY_BYTE, bsfd_pkg::ESCAPE_BYTE, 79, 0, 1'b0, 6);
      run_phase(8'($urandom_range(255)), 8'($urandom_range(255)), 0, 79, 1'b0, 6);
      run_phase(8'hFF, 8'h00, 36, 36, 1'b0, 6);

      settle_block();
      repeat (20) @(posedge clock);
      if (deframer_sb.errors == 0 && deframer_sb.beats_pending() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // Bound the run
   initial begin
      #2000000;
      $display("status: fail");
      $finish;
   end

endmodule
